@@ hdl/tmlp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tile map lattice line plotter package
// Shared widths, command codes and the step descriptor passed from the
// step calculator to the plotter.
// ----------------------------------------------------------------------------
package tmlp_pkg;

   localparam int COORD_W        = 6;
   localparam int DEF_MAP_WIDTH  = 64;
   localparam int DEF_MAP_HEIGHT = 64;

   // Command codes on req_func.
   localparam logic [1:0] FUNC_SET   = 2'd0;
   localparam logic [1:0] FUNC_CLEAR = 2'd1;
   localparam logic [1:0] FUNC_WALL  = 2'd2;

   // Result of the step calculation for one wall.
   typedef struct packed {
      logic [COORD_W-1:0] gcd;
      logic [COORD_W-1:0] step_x;
      logic [COORD_W-1:0] step_y;
   } tmlp_step_type;

endpackage

@@ hdl/tmlp_step_calc.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tile map lattice line plotter step calculator
// Computes g = gcd(|dx|,|dy|) and the step magnitudes |dx|/g and |dy|/g with
// one shared subtractor under a small sequencer.
// ----------------------------------------------------------------------------
module tmlp_step_calc (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [tmlp_pkg::COORD_W-1:0]  dx_mag,
   input  logic [tmlp_pkg::COORD_W-1:0]  dy_mag,
   output logic                          done,
   output tmlp_pkg::tmlp_step_type       step
);
   import tmlp_pkg::*;

   localparam int SH_W  = $clog2(COORD_W);
   localparam int CNT_W = $clog2(COORD_W);

   typedef enum logic [1:0] {S_IDLE, S_GCD, S_DIVX, S_DIVY} state_type;

   state_type            state_ff, state_in;
   logic [COORD_W-1:0]   a_ff, a_in;
   logic [COORD_W-1:0]   b_ff, b_in;
   logic [SH_W-1:0]      shift_ff, shift_in;
   logic [COORD_W-1:0]   gcd_ff, gcd_in;
   logic [COORD_W-1:0]   dxm_ff, dxm_in;
   logic [COORD_W-1:0]   dym_ff, dym_in;
   logic [COORD_W-1:0]   rem_ff, rem_in;
   logic [COORD_W-1:0]   num_ff, num_in;
   logic [COORD_W-1:0]   quo_ff, quo_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [COORD_W-1:0]   stx_ff, stx_in;
   logic [COORD_W-1:0]   sty_ff, sty_in;
   logic                 done_ff, done_in;

   // The shared subtractor, used by both the gcd and the division steps.
   logic [COORD_W:0]     op_a;
   logic [COORD_W:0]     op_b;
   logic [COORD_W+1:0]   diff;
   logic                 ge;
   logic [COORD_W-1:0]   quo_next;
   logic [COORD_W-1:0]   rem_next;

   always_comb begin
      if (state_ff == S_GCD) begin
         op_a = {1'b0, a_ff};
         op_b = {1'b0, b_ff};
      end else begin
         op_a = {rem_ff, num_ff[COORD_W-1]};
         op_b = {1'b0, gcd_ff};
      end
      diff     = {1'b0, op_a} - {1'b0, op_b};
      ge       = ~diff[COORD_W+1];
      quo_next = {quo_ff[COORD_W-2:0], ge};
      rem_next = ge ? diff[COORD_W-1:0] : op_a[COORD_W-1:0];
   end

   always_comb begin
      state_in = state_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      shift_in = shift_ff;
      gcd_in   = gcd_ff;
      dxm_in   = dxm_ff;
      dym_in   = dym_ff;
      rem_in   = rem_ff;
      num_in   = num_ff;
      quo_in   = quo_ff;
      cnt_in   = cnt_ff;
      stx_in   = stx_ff;
      sty_in   = sty_ff;
      done_in  = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               a_in     = dx_mag;
               b_in     = dy_mag;
               dxm_in   = dx_mag;
               dym_in   = dy_mag;
               shift_in = '0;
               state_in = S_GCD;
            end
         end
         S_GCD: begin
            // Binary gcd: halve even operands, subtract odd ones.
            priority if (a_ff == '0 || b_ff == '0) begin
               gcd_in = COORD_W'((a_ff | b_ff) << shift_ff);
               if ((a_ff | b_ff) == '0) begin
                  done_in  = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  rem_in   = '0;
                  num_in   = dxm_ff;
                  quo_in   = '0;
                  cnt_in   = '0;
                  state_in = S_DIVX;
               end
            end else if (!a_ff[0] && !b_ff[0]) begin
               a_in     = a_ff >> 1;
               b_in     = b_ff >> 1;
               shift_in = shift_ff + 1'b1;
            end else if (!a_ff[0]) begin
               a_in = a_ff >> 1;
            end else if (!b_ff[0]) begin
               b_in = b_ff >> 1;
            end else if (ge) begin
               a_in = diff[COORD_W:1];
            end else begin
               a_in = b_ff;
               b_in = a_ff;
            end
         end
         S_DIVX: begin
            rem_in = rem_next;
            quo_in = quo_next;
            num_in = num_ff << 1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(COORD_W - 1)) begin
               stx_in   = quo_next;
               rem_in   = '0;
               num_in   = dym_ff;
               quo_in   = '0;
               cnt_in   = '0;
               state_in = S_DIVY;
            end
         end
         S_DIVY: begin
            rem_in = rem_next;
            quo_in = quo_next;
            num_in = num_ff << 1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(COORD_W - 1)) begin
               sty_in   = quo_next;
               done_in  = 1'b1;
               state_in = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      a_ff     <= a_in;
      b_ff     <= b_in;
      shift_ff <= shift_in;
      gcd_ff   <= gcd_in;
      dxm_ff   <= dxm_in;
      dym_ff   <= dym_in;
      rem_ff   <= rem_in;
      num_ff   <= num_in;
      quo_ff   <= quo_in;
      cnt_ff   <= cnt_in;
      stx_ff   <= stx_in;
      sty_ff   <= sty_in;
   end

   assign done        = done_ff;
   assign step.gcd    = gcd_ff;
   assign step.step_x = stx_ff;
   assign step.step_y = sty_ff;

endmodule

@@ hdl/tile_map_lattice_line_plotter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tile map lattice line plotter
// One-bit tile bitmap with set, clear and wall drawing commands. Every tile
// touched returns its coordinates, its previous bit and a last flag.
// ----------------------------------------------------------------------------
// Usage: a command transaction on the req_ channel carries req_func (set tile,
// clear tile or draw wall) and the start and end coordinates. req_stall stays
// high while a command is worked on, so commands are taken one at a time. Each
// tile touched gives one rsp_ transaction, in order, with rsp_last high on the
// final tile of the command. An unused command code is taken and gives nothing.
// Sequence: a set or clear touches one tile. A wall runs a binary gcd on a
// shared subtractor, two 6-step restoring divisions for the step sizes, then
// writes its g+1 tiles, one per cycle while the output is not stalled.
// Reset: synchronous and active high. The block then clears the tile memory,
// all MAP_WIDTH*MAP_HEIGHT entries at one per cycle, with req_stall held high.
// Backpressure: rsp_stall holds the output register; the plotter then pauses
// with its next tile already read, and resumes without losing any result.
// ----------------------------------------------------------------------------
module tile_map_lattice_line_plotter #(
   parameter int MAP_WIDTH  = tmlp_pkg::DEF_MAP_WIDTH,
   parameter int MAP_HEIGHT = tmlp_pkg::DEF_MAP_HEIGHT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_func,
   input  logic [tmlp_pkg::COORD_W-1:0]  req_start_x,
   input  logic [tmlp_pkg::COORD_W-1:0]  req_start_y,
   input  logic [tmlp_pkg::COORD_W-1:0]  req_end_x,
   input  logic [tmlp_pkg::COORD_W-1:0]  req_end_y,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [tmlp_pkg::COORD_W-1:0]  rsp_tile_x,
   output logic [tmlp_pkg::COORD_W-1:0]  rsp_tile_y,
   output logic                          rsp_old_bit,
   output logic                          rsp_last
);
   import tmlp_pkg::*;

   localparam int DEPTH  = MAP_WIDTH * MAP_HEIGHT;
   localparam int ADDR_W = $clog2(DEPTH);

   typedef enum logic [1:0] {T_CLEAR, T_IDLE, T_CALC, T_PLOT} state_type;

   // True when the tile lies inside the map; tiles outside are never stored.
   function automatic logic in_map(input logic [COORD_W-1:0] x,
                                   input logic [COORD_W-1:0] y);
      in_map = ({{(32-COORD_W){1'b0}}, x} < 32'(MAP_WIDTH)) &&
               ({{(32-COORD_W){1'b0}}, y} < 32'(MAP_HEIGHT));
   endfunction

   // Row-major address; only meaningful for tiles inside the map.
   function automatic logic [ADDR_W-1:0] tile_addr(input logic [COORD_W-1:0] x,
                                                   input logic [COORD_W-1:0] y);
      tile_addr = ADDR_W'(y) * ADDR_W'(MAP_WIDTH) + ADDR_W'(x);
   endfunction

   // Sequencer and clearing pass.
   state_type            state_ff, state_in;
   logic [ADDR_W-1:0]    clr_addr_ff, clr_addr_in;

   // Command registers.
   logic [COORD_W-1:0]   org_x_ff, org_x_in;
   logic [COORD_W-1:0]   org_y_ff, org_y_in;
   logic                 neg_x_ff, neg_x_in;
   logic                 neg_y_ff, neg_y_in;
   logic                 wval_ff, wval_in;

   // Read stage: the next tile to be read from the memory.
   logic                 cur_valid_ff, cur_valid_in;
   logic [COORD_W-1:0]   cur_x_ff, cur_x_in;
   logic [COORD_W-1:0]   cur_y_ff, cur_y_in;
   logic [COORD_W-1:0]   rem_ff, rem_in;

   // Write stage: the tile whose old bit sits in rd_bit_ff.
   logic                 h_valid_ff, h_valid_in;
   logic [COORD_W-1:0]   h_x_ff, h_x_in;
   logic [COORD_W-1:0]   h_y_ff, h_y_in;
   logic                 h_last_ff, h_last_in;
   logic                 h_inmap_ff, h_inmap_in;

   // Output register.
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [COORD_W-1:0]   rsp_x_ff, rsp_x_in;
   logic [COORD_W-1:0]   rsp_y_ff, rsp_y_in;
   logic                 rsp_old_ff, rsp_old_in;
   logic                 rsp_last_ff, rsp_last_in;

   // Tile memory.
   logic                 tile_mem [DEPTH];
   logic                 rd_bit_ff;
   logic                 mem_we;
   logic [ADDR_W-1:0]    mem_waddr;
   logic                 mem_wdata;
   logic                 mem_re;
   logic [ADDR_W-1:0]    mem_raddr;

   // Step calculator.
   logic                 calc_start;
   logic [COORD_W-1:0]   dx_mag;
   logic [COORD_W-1:0]   dy_mag;
   logic                 calc_done;
   tmlp_step_type        calc_step;

   logic                 cur_inmap;
   logic                 out_free;
   logic                 advance;

   tmlp_step_calc u_step_calc (
      .clock  (clock),
      .reset  (reset),
      .start  (calc_start),
      .dx_mag (dx_mag),
      .dy_mag (dy_mag),
      .done   (calc_done),
      .step   (calc_step)
   );

   assign req_stall = (state_ff != T_IDLE);
   assign cur_inmap = in_map(cur_x_ff, cur_y_ff);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   // The write stage moves on when it is empty or its result can be taken.
   assign advance   = !h_valid_ff || out_free;

   // Wall deltas are formed as magnitude and direction.
   always_comb begin
      neg_x_in = (req_end_x < req_start_x);
      neg_y_in = (req_end_y < req_start_y);
      dx_mag   = neg_x_in ? (req_start_x - req_end_x) : (req_end_x - req_start_x);
      dy_mag   = neg_y_in ? (req_start_y - req_end_y) : (req_end_y - req_start_y);
   end

   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      org_x_in     = org_x_ff;
      org_y_in     = org_y_ff;
      wval_in      = wval_ff;
      cur_valid_in = cur_valid_ff;
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      rem_in       = rem_ff;
      h_valid_in   = h_valid_ff;
      h_x_in       = h_x_ff;
      h_y_in       = h_y_ff;
      h_last_in    = h_last_ff;
      h_inmap_in   = h_inmap_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_old_in   = rsp_old_ff;
      rsp_last_in  = rsp_last_ff;
      mem_we       = 1'b0;
      mem_waddr    = '0;
      mem_wdata    = 1'b0;
      mem_re       = 1'b0;
      mem_raddr    = '0;
      calc_start   = 1'b0;

      unique case (state_ff)
         T_CLEAR: begin
            mem_we      = 1'b1;
            mem_waddr   = clr_addr_ff;
            mem_wdata   = 1'b0;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = T_IDLE;
            end
         end
         T_IDLE: begin
            if (req_valid) begin
               org_x_in = req_start_x;
               org_y_in = req_start_y;
               unique case (req_func)
                  FUNC_SET, FUNC_CLEAR: begin
                     cur_x_in     = req_start_x;
                     cur_y_in     = req_start_y;
                     rem_in       = '0;
                     cur_valid_in = 1'b1;
                     wval_in      = (req_func == FUNC_SET);
                     state_in     = T_PLOT;
                  end
                  FUNC_WALL: begin
                     calc_start = 1'b1;
                     wval_in    = 1'b1;
                     state_in   = T_CALC;
                  end
                  default: begin
                     // Unused code: the transaction is dropped.
                  end
               endcase
            end
         end
         T_CALC: begin
            // A zero gcd means equal endpoints: a single tile at the start.
            if (calc_done) begin
               cur_x_in     = org_x_ff;
               cur_y_in     = org_y_ff;
               rem_in       = calc_step.gcd;
               cur_valid_in = 1'b1;
               state_in     = T_PLOT;
            end
         end
         T_PLOT: begin
            if (advance) begin
               if (h_valid_ff) begin
                  mem_we       = h_inmap_ff;
                  mem_waddr    = tile_addr(h_x_ff, h_y_ff);
                  mem_wdata    = wval_ff;
                  rsp_valid_in = 1'b1;
                  rsp_x_in     = h_x_ff;
                  rsp_y_in     = h_y_ff;
                  rsp_old_in   = rd_bit_ff && h_inmap_ff;
                  rsp_last_in  = h_last_ff;
               end
               if (cur_valid_ff) begin
                  // Successive tiles of a wall differ, so the read never
                  // meets the write of the same cycle.
                  mem_re     = 1'b1;
                  mem_raddr  = cur_inmap ? tile_addr(cur_x_ff, cur_y_ff) : '0;
                  h_valid_in = 1'b1;
                  h_x_in     = cur_x_ff;
                  h_y_in     = cur_y_ff;
                  h_last_in  = (rem_ff == '0);
                  h_inmap_in = cur_inmap;
                  if (rem_ff == '0) begin
                     cur_valid_in = 1'b0;
                  end else begin
                     rem_in   = rem_ff - 1'b1;
                     cur_x_in = neg_x_ff ? (cur_x_ff - calc_step.step_x)
                                         : (cur_x_ff + calc_step.step_x);
                     cur_y_in = neg_y_ff ? (cur_y_ff - calc_step.step_y)
                                         : (cur_y_ff + calc_step.step_y);
                  end
               end else begin
                  h_valid_in = 1'b0;
                  state_in   = T_IDLE;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_CLEAR;
         clr_addr_ff  <= '0;
         cur_valid_ff <= 1'b0;
         h_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         cur_valid_ff <= cur_valid_in;
         h_valid_ff   <= h_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (state_ff == T_IDLE) begin
         neg_x_ff <= neg_x_in;
         neg_y_ff <= neg_y_in;
      end
      org_x_ff    <= org_x_in;
      org_y_ff    <= org_y_in;
      wval_ff     <= wval_in;
      cur_x_ff    <= cur_x_in;
      cur_y_ff    <= cur_y_in;
      rem_ff      <= rem_in;
      h_x_ff      <= h_x_in;
      h_y_ff      <= h_y_in;
      h_last_ff   <= h_last_in;
      h_inmap_ff  <= h_inmap_in;
      rsp_x_ff    <= rsp_x_in;
      rsp_y_ff    <= rsp_y_in;
      rsp_old_ff  <= rsp_old_in;
      rsp_last_ff <= rsp_last_in;
   end

   // Tile memory: one write port and one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         tile_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_bit_ff <= tile_mem[mem_raddr];
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_tile_x  = rsp_x_ff;
   assign rsp_tile_y  = rsp_y_ff;
   assign rsp_old_bit = rsp_old_ff;
   assign rsp_last    = rsp_last_ff;

endmodule
